### sv/cpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

  // Sizing
  localparam int unsigned MAX_LEN     = 16;
  localparam int unsigned TABLE_DEPTH = 128;

  // Fixed field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned INDEX_W    = 64;
  localparam int unsigned CHARSET_W  = 8;
  localparam int unsigned PASS_LEN_W = 5;
  localparam int unsigned CHAR_POS_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Derived widths
  localparam int unsigned DIGIT_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned TBL_AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned RADIX_W    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W      = RADIX_W + 1;
  localparam int unsigned LEN_W      = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_LEN);
  localparam int unsigned DIV_CNT_W  = $clog2(INDEX_W + 1);

  // Config reset values
  localparam logic [CHARSET_W-1:0]  CHARSET_RST  = CHARSET_W'(66);
  localparam logic [PASS_LEN_W-1:0] PASS_LEN_RST = PASS_LEN_W'(1);
  localparam logic [INDEX_W-1:0]    RANGE_RST    = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_SEEK = 2'd1,
    REQ_NEXT = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARSET_SIZE = 2'd0,
    CFG_PASS_LENGTH  = 2'd1,
    CFG_RANGE_END    = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

### sv/cpg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cpg_req_if;
  logic                             valid;
  logic                             ready;
  logic [cpg_pkg::REQ_W-1:0]        req_type;
  logic [cpg_pkg::SLOT_W-1:0]       table_slot;
  logic [cpg_pkg::CHAR_W-1:0]       table_char;
  logic [cpg_pkg::INDEX_W-1:0]      seek_index;

  modport source (output valid, req_type, table_slot, table_char, seek_index, input ready);
  modport sink   (input valid, req_type, table_slot, table_char, seek_index, output ready);
endinterface

`default_nettype wire

### sv/cpg_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cpg_res_if;
  logic                             valid;
  logic                             ready;
  logic [cpg_pkg::CHAR_W-1:0]       char_out;
  logic [cpg_pkg::CHAR_POS_W-1:0]   char_pos;
  logic                             last_char;
  logic                             done_res;

  modport source (output valid, char_out, char_pos, last_char, done_res, input ready);
  modport sink   (input valid, char_out, char_pos, last_char, done_res, output ready);
endinterface

`default_nettype wire

### sv/cpg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cpg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/cpg_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cpg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [cpg_pkg::INDEX_W-1:0]   dividend_i,
  input  wire logic [cpg_pkg::RADIX_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic      [cpg_pkg::INDEX_W-1:0]   quot_o,
  output logic      [cpg_pkg::DIGIT_W-1:0]   rem_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [cpg_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [cpg_pkg::INDEX_W-1:0]     quo_q, quo_d;
  logic [cpg_pkg::RADIX_W-1:0]     rem_q, rem_d;
  logic [cpg_pkg::RADIX_W-1:0]     dvs_q, dvs_d;
  logic [cpg_pkg::CMP_W-1:0]       trial;
  logic [cpg_pkg::CMP_W-1:0]       diff;
  logic                            ge;

  assign trial = {rem_q, quo_q[cpg_pkg::INDEX_W-1]};
  assign ge    = trial >= cpg_pkg::CMP_W'(dvs_q);
  assign diff  = trial - cpg_pkg::CMP_W'(dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = cpg_pkg::DIV_CNT_W'(cpg_pkg::INDEX_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[cpg_pkg::INDEX_W-2:0], ge};
      rem_d = ge ? diff[cpg_pkg::RADIX_W-1:0] : trial[cpg_pkg::RADIX_W-1:0];
      cnt_d = cnt_q - cpg_pkg::DIV_CNT_W'(1);
      if (cnt_q == cpg_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[cpg_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

### sv/charset_password_candidate_generator.sv
// Load: written to the table on accept, no result; the next request can follow at once.
// Seek: one serial 64-bit division per base-N digit up to the top nonzero one (radix 1
//   runs all L), each kicked from SEEK and waited on in SDIV, rightmost digit first.
// Next: RD starts the first table read, then WR sends one beat per cycle while the
//   output is free, then ADV ripples the carry; exhausted or at range end, one done beat.
// Reset clears digits, count and exhausted flag; table is unknown until loaded.
`timescale 1ns / 1ps
`default_nettype none

module charset_password_candidate_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cpg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cpg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  cpg_req_if.sink                                req_i,
  cpg_res_if.source                              res_o
);

  // One-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEEK = 7'b0000010,  // check remaining value, kick divider
    ST_SDIV = 7'b0000100,  // wait for quotient/remainder
    ST_RD   = 7'b0001000,  // first table read of a candidate
    ST_WR   = 7'b0010000,  // one character beat per cycle while the output is free
    ST_ADV  = 7'b0100000,  // odometer carry, one digit per cycle
    ST_DONE = 7'b1000000   // single done beat
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [cpg_pkg::CHARSET_W-1:0]   cs_q;
  logic [cpg_pkg::PASS_LEN_W-1:0]  pl_q;
  logic [cpg_pkg::INDEX_W-1:0]     rend_q;

  // Generator state
  logic [cpg_pkg::DIGIT_W-1:0]     digits_q [cpg_pkg::MAX_LEN];
  logic [cpg_pkg::DIGIT_W-1:0]     digits_d [cpg_pkg::MAX_LEN];
  logic [cpg_pkg::INDEX_W-1:0]     pos_q, pos_d;
  logic                            exh_q, exh_d;
  logic [cpg_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [cpg_pkg::INDEX_W-1:0]     val_q, val_d;

  // Output register
  logic                            ovld_q, ovld_d;
  logic [cpg_pkg::CHAR_W-1:0]      ochar_q, ochar_d;
  logic [cpg_pkg::CHAR_POS_W-1:0]  opos_q, opos_d;
  logic                            olast_q, olast_d;
  logic                            odone_q, odone_d;

  logic                            acc;
  logic                            out_free;
  logic [cpg_pkg::RADIX_W-1:0]     radix;
  logic [cpg_pkg::LEN_W-1:0]       len_eff;
  logic [cpg_pkg::IDX_W-1:0]       last_idx;
  logic [cpg_pkg::IDX_W-1:0]       idx_inc;
  logic [cpg_pkg::CMP_W-1:0]       dig_inc;

  // Table RAM
  logic                            ram_we, ram_re;
  logic [cpg_pkg::TBL_AW-1:0]      ram_raddr;
  logic [cpg_pkg::CHAR_W-1:0]      ram_rdata;

  // Divider
  logic                            div_start, div_done;
  logic [cpg_pkg::INDEX_W-1:0]     div_quot;
  logic [cpg_pkg::DIGIT_W-1:0]     div_rem;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign out_free    = !ovld_q || res_o.ready;

  // Clamp radix and length to what the table and digit file hold
  always_comb begin
    priority if (cs_q == '0) begin
      radix = cpg_pkg::RADIX_W'(1);
    end else if (int'(cs_q) > cpg_pkg::TABLE_DEPTH) begin
      radix = cpg_pkg::RADIX_W'(cpg_pkg::TABLE_DEPTH);
    end else begin
      radix = cpg_pkg::RADIX_W'(cs_q);
    end
    priority if (pl_q == '0) begin
      len_eff = cpg_pkg::LEN_W'(1);
    end else if (int'(pl_q) > cpg_pkg::MAX_LEN) begin
      len_eff = cpg_pkg::LEN_W'(cpg_pkg::MAX_LEN);
    end else begin
      len_eff = cpg_pkg::LEN_W'(pl_q);
    end
  end

  assign last_idx = cpg_pkg::IDX_W'(len_eff - cpg_pkg::LEN_W'(1));
  assign idx_inc  = idx_q + cpg_pkg::IDX_W'(1);
  // shared increment/compare for the carry ripple
  assign dig_inc  = cpg_pkg::CMP_W'(digits_q[idx_q]) + cpg_pkg::CMP_W'(1);

  // Load writes go straight to the table on the accept edge
  assign ram_we    = acc && (req_i.req_type == cpg_pkg::REQ_LOAD)
                     && (int'(req_i.table_slot) < cpg_pkg::TABLE_DEPTH);
  // In WR the read runs one character ahead
  assign ram_raddr = (state_q == ST_WR) ? digits_q[idx_inc] : digits_q[idx_q];

  always_comb begin
    state_d   = state_q;
    digits_d  = digits_q;
    pos_d     = pos_q;
    exh_d     = exh_q;
    idx_d     = idx_q;
    val_d     = val_q;
    ovld_d    = ovld_q && !res_o.ready;
    ochar_d   = ochar_q;
    opos_d    = opos_q;
    olast_d   = olast_q;
    odone_d   = odone_q;
    ram_re    = 1'b0;
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          priority if (req_i.req_type == cpg_pkg::REQ_SEEK) begin
            for (int i = 0; i < cpg_pkg::MAX_LEN; i++) begin
              digits_d[i] = '0;
            end
            pos_d   = req_i.seek_index;
            val_d   = req_i.seek_index;
            exh_d   = 1'b0;
            idx_d   = last_idx;
            state_d = ST_SEEK;
          end else if (req_i.req_type == cpg_pkg::REQ_NEXT) begin
            idx_d = '0;
            if (exh_q || (pos_q >= rend_q)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_RD;
            end
          end else begin
            state_d = ST_IDLE;  // load handled by the RAM port, nop ignored
          end
        end
      end
      ST_SEEK: begin
        if (val_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (div_done) begin
          digits_d[idx_q] = div_rem;
          val_d           = div_quot;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - cpg_pkg::IDX_W'(1);
            state_d = ST_SEEK;
          end
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ochar_d = ram_rdata;
          opos_d  = cpg_pkg::CHAR_POS_W'(idx_q);
          olast_d = (idx_q == last_idx);
          odone_d = 1'b0;
          if (idx_q == last_idx) begin
            pos_d   = pos_q + cpg_pkg::INDEX_W'(1);
            state_d = ST_ADV;
          end else begin
            ram_re = 1'b1;
            idx_d  = idx_inc;
          end
        end
      end
      ST_ADV: begin
        // idx_q starts at the rightmost digit
        if (dig_inc >= cpg_pkg::CMP_W'(radix)) begin
          digits_d[idx_q] = '0;
          if (idx_q == '0) begin
            exh_d   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - cpg_pkg::IDX_W'(1);
          end
        end else begin
          digits_d[idx_q] = dig_inc[cpg_pkg::DIGIT_W-1:0];
          state_d         = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ochar_d = '0;
          opos_d  = '0;
          olast_d = 1'b1;
          odone_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cs_q    <= cpg_pkg::CHARSET_RST;
      pl_q    <= cpg_pkg::PASS_LEN_RST;
      rend_q  <= cpg_pkg::RANGE_RST;
      pos_q   <= '0;
      exh_q   <= 1'b0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < cpg_pkg::MAX_LEN; i++) begin
        digits_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      exh_q    <= exh_d;
      idx_q    <= idx_d;
      ovld_q   <= ovld_d;
      digits_q <= digits_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cpg_pkg::CFG_CHARSET_SIZE: cs_q   <= cfg_wdata_i[cpg_pkg::CHARSET_W-1:0];
          cpg_pkg::CFG_PASS_LENGTH:  pl_q   <= cfg_wdata_i[cpg_pkg::PASS_LEN_W-1:0];
          cpg_pkg::CFG_RANGE_END:    rend_q <= cfg_wdata_i[cpg_pkg::INDEX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    ochar_q <= ochar_d;
    opos_q  <= opos_d;
    olast_q <= olast_d;
    odone_q <= odone_d;
  end

  assign res_o.valid     = ovld_q;
  assign res_o.char_out  = ochar_q;
  assign res_o.char_pos  = opos_q;
  assign res_o.last_char = olast_q;
  assign res_o.done_res  = odone_q;

  cpg_ram #(
    .WIDTH (cpg_pkg::CHAR_W),
    .DEPTH (cpg_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cpg_pkg::TBL_AW'(req_i.table_slot)),
    .wdata_i (req_i.table_char),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (val_q),
    .divisor_i  (radix),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

endmodule

`default_nettype wire
